// ----- sv/bb3b_pkg.sv -----
package bb3b_pkg;

    // Sizes
    localparam int MAX_LINE_DEF = 2048;
    localparam int PIX_W        = 24;
    localparam int COORD_W      = 11;
    localparam int DIM_W        = 12;
    localparam int WEIGHT_W     = 9;
    localparam int SUM_W        = 12;   // nine bytes, or one byte times nine
    localparam int PROD_W       = 20;   // 2295 * 256 at most
    localparam int RECIP_W      = 24;   // 2295 * 7282 at most
    localparam int RECIP_SHIFT  = 16;

    // Limits of the configuration
    localparam logic [DIM_W-1:0]    DIM_MIN           = 12'd3;
    localparam logic [DIM_W-1:0]    DIM_MAX           = 12'd2048;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL       = 9'd256;
    localparam logic [WEIGHT_W-1:0] BLEND_MIN_WEIGHT  = 9'd26;

    // ceil(2^16 / 9), exact floor(y/9) for y up to 2295
    localparam logic [12:0] RECIP_NINE = 13'd7282;

    // Register reset values
    localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 12'd480;
    localparam logic [WEIGHT_W-1:0] BLUR_WEIGHT_RST  = 9'd128;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLUR_WEIGHT  = 2'd2;

    // Job queue between front and back
    localparam int JOB_DEPTH = 8;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Result slots of one job, in emission order
    localparam int SLOT_DIAG = 0;   // pixel one row up, one column left
    localparam int SLOT_EDGE = 1;   // pixel one row up, same column (row end)
    localparam int SLOT_SELF = 2;   // the new pixel itself (first and last row)
    localparam int SLOT_N    = 3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               frame_done;
    } out_result_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        rgb_t               px;
        rgb_t               center;
        rgb_t               right;
        logic [SLOT_N-1:0]  slots;
        logic               done;
    } job_t;

    // Channel k of a pixel: 0 blue, 1 green, 2 red
    function automatic logic [7:0] chan(input rgb_t p, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = p.blue;
            2'd1:    v = p.green;
            default: v = p.red;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/bb3b_ram.sv -----
module bb3b_ram
    import bb3b_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = MAX_LINE_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bb3b_front.sv -----
module bb3b_front
    import bb3b_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_pixel_t            s_pixel,
    input  logic [DIM_W-1:0]     frame_width,
    input  logic [DIM_W-1:0]     frame_height,
    input  logic [WEIGHT_W-1:0]  blur_weight,
    input  logic [JOB_CNT_W-1:0] fifo_count,
    output logic                 push,
    output job_t                 push_job
);

    localparam int AW      = $clog2(MAX_LINE);
    localparam int LIM     = (MAX_LINE < 2048) ? MAX_LINE : 2048;
    localparam int STAGES  = 5;
    localparam int INFL_W  = $clog2(STAGES + 1);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        rgb_t               px;
        logic [SLOT_N-1:0]  slots;
        logic               done;
        logic               blend;
    } ctl_t;

    // Effective configuration
    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [WEIGHT_W-1:0] wt_eff;
    logic [WEIGHT_W-1:0] wt_inv;

    always_comb begin
        if (frame_width < DIM_MIN) begin
            w_eff = DIM_MIN;
        end else if (frame_width > DIM_W'(LIM)) begin
            w_eff = DIM_W'(LIM);
        end else begin
            w_eff = frame_width;
        end
        if (frame_height < DIM_MIN) begin
            h_eff = DIM_MIN;
        end else if (frame_height > DIM_MAX) begin
            h_eff = DIM_MAX;
        end else begin
            h_eff = frame_height;
        end
        wt_eff = (blur_weight > WEIGHT_FULL) ? WEIGHT_FULL : blur_weight;
        wt_inv = WEIGHT_FULL - wt_eff;
    end

    // Raster position and classification of the incoming pixel
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               accept;
    logic               last_col, last_row;
    ctl_t               ctl_in;
    logic [31:0]        col_ext;
    logic [AW-1:0]      rd_addr;

    assign accept   = s_valid && s_ready;
    assign last_col = {1'b0, col_reg} >= (w_eff - DIM_W'(1));
    assign last_row = {1'b0, row_reg} >= (h_eff - DIM_W'(1));
    assign col_ext  = 32'(col_reg);
    assign rd_addr  = (col_ext < 32'(MAX_LINE)) ? col_ext[AW-1:0] : AW'(MAX_LINE - 1);

    always_comb begin
        ctl_in.row       = row_reg;
        ctl_in.col       = col_reg;
        ctl_in.px.red    = s_pixel.in_red;
        ctl_in.px.green  = s_pixel.in_green;
        ctl_in.px.blue   = s_pixel.in_blue;
        ctl_in.slots[SLOT_DIAG] = (row_reg >= COORD_W'(2)) && (col_reg != '0);
        ctl_in.slots[SLOT_EDGE] = (row_reg >= COORD_W'(2)) && last_col;
        ctl_in.slots[SLOT_SELF] = (row_reg == '0) || last_row;
        ctl_in.done      = (row_reg != '0) && last_row && last_col;
        ctl_in.blend     = (col_reg >= COORD_W'(2))
                         && ({1'b0, col_reg} <= (w_eff - DIM_W'(1)))
                         && (wt_eff >= BLEND_MIN_WEIGHT);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_W'(1);
            end else begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Credit check: queue room for every job still in the pipeline
    logic [INFL_W-1:0] inflight_reg, inflight_next;
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign s_ready = (32'(fifo_count) + 32'(inflight_reg)) < 32'(JOB_DEPTH);
    assign inflight_next = inflight_reg + INFL_W'(accept) - INFL_W'(v5_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
        end else begin
            inflight_reg <= inflight_next;
            v1_reg       <= accept;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
        end
    end

    // Line stores: read on accept, written back in the following cycle
    ctl_t          ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [AW-1:0] addr1_reg;
    logic [PIX_W-1:0] up_q, mid_q;

    bb3b_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_upper (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (addr1_reg),
        .wdata (mid_q),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (up_q)
    );

    bb3b_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_middle (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (addr1_reg),
        .wdata (ctl1_reg.px),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (mid_q)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl1_reg  <= ctl_in;
            addr1_reg <= rd_addr;
        end
    end

    // 3x3 window, column 2 newest
    rgb_t win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (v1_reg) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= rgb_t'(up_q);
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= rgb_t'(mid_q);
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= ctl1_reg.px;
        end
    end

    // Window sums and nine times the center
    logic [SUM_W-1:0] sum_comb [3];
    logic [SUM_W-1:0] orig9_comb [3];
    logic [SUM_W-1:0] sum3_reg [3];
    logic [SUM_W-1:0] orig9_reg [3];
    rgb_t             center3_reg, right3_reg;

    always_comb begin
        logic [7:0] c;
        for (int k = 0; k < 3; k++) begin
            sum_comb[k] = '0;
            for (int i = 0; i < 9; i++) begin
                sum_comb[k] = sum_comb[k] + SUM_W'(chan(win_reg[i], 2'(k)));
            end
            c = chan(win_reg[4], 2'(k));
            orig9_comb[k] = SUM_W'({c, 3'b000}) + SUM_W'(c);
        end
    end

    always_ff @(posedge aclk) begin
        ctl2_reg    <= ctl1_reg;
        ctl3_reg    <= ctl2_reg;
        center3_reg <= win_reg[4];
        right3_reg  <= win_reg[5];
        for (int k = 0; k < 3; k++) begin
            sum3_reg[k]  <= sum_comb[k];
            orig9_reg[k] <= orig9_comb[k];
        end
    end

    // Weighted terms
    logic [PROD_W-1:0] prod_a_reg [3];
    logic [PROD_W-1:0] prod_b_reg [3];
    rgb_t              center4_reg, right4_reg;

    always_ff @(posedge aclk) begin
        ctl4_reg    <= ctl3_reg;
        center4_reg <= center3_reg;
        right4_reg  <= right3_reg;
        for (int k = 0; k < 3; k++) begin
            prod_a_reg[k] <= PROD_W'(orig9_reg[k]) * PROD_W'(wt_inv);
            prod_b_reg[k] <= PROD_W'(sum3_reg[k]) * PROD_W'(wt_eff);
        end
    end

    // Divide by 2304: shift by 8, then multiply by the reciprocal of 9
    logic [PROD_W-1:0]  total_comb [3];
    logic [RECIP_W-1:0] quot_reg [3];
    rgb_t               center5_reg, right5_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            total_comb[k] = prod_a_reg[k] + prod_b_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        ctl5_reg    <= ctl4_reg;
        center5_reg <= center4_reg;
        right5_reg  <= right4_reg;
        for (int k = 0; k < 3; k++) begin
            quot_reg[k] <= RECIP_W'(total_comb[k][PROD_W-1:8]) * RECIP_W'(RECIP_NINE);
        end
    end

    // Job assembly
    rgb_t blended;

    always_comb begin
        blended.blue  = quot_reg[0][RECIP_W-1:RECIP_SHIFT];
        blended.green = quot_reg[1][RECIP_W-1:RECIP_SHIFT];
        blended.red   = quot_reg[2][RECIP_W-1:RECIP_SHIFT];

        push_job.row    = ctl5_reg.row;
        push_job.col    = ctl5_reg.col;
        push_job.px     = ctl5_reg.px;
        push_job.center = ctl5_reg.blend ? blended : center5_reg;
        push_job.right  = right5_reg;
        push_job.slots  = ctl5_reg.slots;
        push_job.done   = ctl5_reg.done;
    end

    // Pixels with no result are dropped here
    assign push = v5_reg && (ctl5_reg.slots != '0);

endmodule

// ----- sv/bb3b_job_fifo.sv -----
module bb3b_job_fifo
    import bb3b_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  job_t                 push_job,
    input  logic                 pop,
    output job_t                 head,
    output logic                 empty,
    output logic [JOB_CNT_W-1:0] count
);

    job_t                 mem_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg, count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1))
                        ? '0 : wr_ptr_reg + JOB_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1))
                        ? '0 : rd_ptr_reg + JOB_PTR_W'(1);
        end
        count_next = count_reg + JOB_CNT_W'(push) - JOB_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/bb3b_back.sv -----
module bb3b_back
    import bb3b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fifo_empty,
    input  job_t        head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output out_result_t m_result
);

    logic [SLOT_N-1:0] sent_reg, sent_next;
    logic [SLOT_N-1:0] remain;
    logic [SLOT_N-1:0] sel;
    logic              load;
    logic              last_slot;
    logic              m_valid_reg, m_valid_next;
    out_result_t       m_result_reg, res;

    // Pick the lowest slot of the head job not yet sent
    assign remain = head.slots & ~sent_reg;

    always_comb begin
        sel = '0;
        if (remain[SLOT_DIAG]) begin
            sel[SLOT_DIAG] = 1'b1;
        end else if (remain[SLOT_EDGE]) begin
            sel[SLOT_EDGE] = 1'b1;
        end else begin
            sel[SLOT_SELF] = 1'b1;
        end
    end

    assign load      = !fifo_empty && (!m_valid_reg || m_ready);
    assign last_slot = (remain & ~sel) == '0;
    assign pop       = load && last_slot;

    // Result for the selected slot
    always_comb begin
        res.out_row    = head.row;
        res.out_col    = head.col;
        res.out_red    = head.px.red;
        res.out_green  = head.px.green;
        res.out_blue   = head.px.blue;
        res.frame_done = head.done;
        if (sel[SLOT_DIAG]) begin
            res.out_row    = head.row - COORD_W'(1);
            res.out_col    = head.col - COORD_W'(1);
            res.out_red    = head.center.red;
            res.out_green  = head.center.green;
            res.out_blue   = head.center.blue;
            res.frame_done = 1'b0;
        end else if (sel[SLOT_EDGE]) begin
            res.out_row    = head.row - COORD_W'(1);
            res.out_red    = head.right.red;
            res.out_green  = head.right.green;
            res.out_blue   = head.right.blue;
            res.frame_done = 1'b0;
        end
    end

    always_comb begin
        sent_next    = sent_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            sent_next    = last_slot ? '0 : (sent_reg | sel);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sent_reg    <= sent_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ----- sv/box_blur_3x3_blend_unit.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_pixel  (in_blue, in_green, in_red)
// m_       out        m_valid/m_ready    m_result (row, col, channels, frame_done)
// APB      in/out     psel/penable       frame_width @0, frame_height @4, blur_weight @8
//
// One pixel per clock is accepted while s_ready is high; a pixel yields zero to three
// results, one per clock at the output while m_ready is high, the extra ones falling
// at row ends and in the last row. Stages to the job queue: line store read, window
// shift, window sum, weighted products, reciprocal of nine; then the output register.
// s_ready drops only when the eight-entry job queue plus the jobs still in the pipeline
// would overflow it, so a stalled m_ready stops intake after a few pixels.
// Synchronous active-low reset clears the raster position, window and queue;
// line stores are not cleared and need no clearing pass.
module box_blur_3x3_blend_unit
    import bb3b_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_pixel_t             s_pixel,
    // Result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_result_t           m_result
);

    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [WEIGHT_W-1:0] blur_weight_reg;
    logic [1:0]          reg_index;
    logic                reg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign reg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            blur_weight_reg  <= BLUR_WEIGHT_RST;
        end else if (reg_write) begin
            unique case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                REG_BLUR_WEIGHT:  blur_weight_reg  <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_index)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            REG_BLUR_WEIGHT:  prdata = APB_DATA_W'(blur_weight_reg);
            default:          prdata = '0;
        endcase
    end

    logic                 push, pop, fifo_empty;
    job_t                 push_job, head;
    logic [JOB_CNT_W-1:0] fifo_count;

    bb3b_front #(.MAX_LINE(MAX_LINE)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .blur_weight  (blur_weight_reg),
        .fifo_count   (fifo_count),
        .push         (push),
        .push_job     (push_job)
    );

    bb3b_job_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty),
        .count    (fifo_count)
    );

    bb3b_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

endmodule
